// ===== hdl/sgci_pkg.sv =====
`timescale 1ns / 1ps
package sgci_pkg;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [7:0] pins_port0;
      logic [7:0] pins_port1;
      logic [7:0] pins_port2;
      logic [7:0] pins_port3;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       reply_last;
      logic [7:0] latch_port0;
      logic [7:0] latch_port1;
      logic [7:0] latch_port2;
      logic [7:0] latch_port3;
   } rsp_type;

   // classified command handed from front to back
   typedef enum logic [2:0] {
      CMD_ERR,
      CMD_PING,
      CMD_SET,
      CMD_GET,
      CMD_WRP,
      CMD_RDP
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] port;
      logic [2:0] bit_sel;
      logic       value;
      logic [7:0] data;
      logic [31:0] pins;
   } job_type;

   typedef enum logic [2:0] {
      FS_COLLECT,
      FS_READ,
      FS_SCAN,
      FS_DECIDE,
      FS_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_EXEC,
      BS_SEND
   } back_state_type;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b0, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
   endfunction

endpackage

// ===== hdl/sgci_ram.sv =====
`timescale 1ns / 1ps
module sgci_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sgci_front.sv =====
`timescale 1ns / 1ps
module sgci_front
   import sgci_pkg::*;
#(
   parameter int LineCapacity = 32,
   parameter int TokenLimit   = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);

   localparam int AW = $clog2(LineCapacity);
   localparam int TW = $clog2(TokenLimit + 2);

   front_state_type state_ff, state_in;
   logic [AW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [TW-1:0] ntok_ff, ntok_in;
   logic [2:0]    tpos_ff, tpos_in;
   logic          intok_ff, intok_in;
   logic          many_ff, many_in;
   logic [31:0]   pins_ff, pins_in;
   // token contents needed for classification
   logic [7:0]    t0_ff [4];
   logic [7:0]    t0_in [4];
   logic [2:0]    t0len_ff, t0len_in;
   logic [7:0]    t1_ff, t1_in;
   logic          t1one_ff, t1one_in;
   logic [7:0]    t2_ff [2];
   logic [7:0]    t2_in [2];
   logic [1:0]    t2len_ff, t2len_in;
   logic [7:0]    t3_ff, t3_in;
   logic          t3one_ff, t3one_in;
   job_type       job_ff, job_in;

   logic          wr_en;
   logic [7:0]    rd_data;
   logic          is_end;
   logic          blank;
   logic          rd_valid_ff;

   sgci_ram #(.Width(8), .Depth(LineCapacity)) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff),
      .wr_data (req_data.rx_byte),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign is_end = req_data.rx_byte == CHAR_CR || req_data.rx_byte == CHAR_LF;
   assign req_ready = state_ff == FS_COLLECT;
   assign wr_en = req_valid && req_ready && !is_end
                  && len_ff != AW'(LineCapacity - 1);
   assign blank = rd_data == CHAR_SP || rd_data == CHAR_TAB;
   assign job_valid = state_ff == FS_PUSH;
   assign job_data = job_ff;

   // state and line bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_COLLECT;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         rd_valid_ff <= state_in == FS_SCAN;
      end
      idx_ff <= idx_in;
      ntok_ff <= ntok_in;
      tpos_ff <= tpos_in;
      intok_ff <= intok_in;
      many_ff <= many_in;
      pins_ff <= pins_in;
      t0_ff <= t0_in;
      t0len_ff <= t0len_in;
      t1_ff <= t1_in;
      t1one_ff <= t1one_in;
      t2_ff <= t2_in;
      t2len_ff <= t2len_in;
      t3_ff <= t3_in;
      t3one_ff <= t3one_in;
      job_ff <= job_in;
   end

   // collect, scan line byte by byte (read state, then scan state), classify
   always_comb begin
      logic [7:0] u;
      logic [3:0] p_d, b_d, v_d;
      logic [4:0] hn, ln;
      logic       kw_ping, kw_set, kw_get, kw_wrp, kw_rdp;
      state_in = state_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      idx_in = idx_ff;
      ntok_in = ntok_ff;
      tpos_in = tpos_ff;
      intok_in = intok_ff;
      many_in = many_ff;
      pins_in = pins_ff;
      t0_in = t0_ff;
      t0len_in = t0len_ff;
      t1_in = t1_ff;
      t1one_in = t1one_ff;
      t2_in = t2_ff;
      t2len_in = t2len_ff;
      t3_in = t3_ff;
      t3one_in = t3one_ff;
      job_in = job_ff;
      u = upcase(t0_ff[0]);
      p_d = t1_ff[3:0];
      b_d = t2_ff[0][3:0];
      v_d = t3_ff[3:0];
      hn = nibble_of(t2_ff[0]);
      ln = nibble_of(t2_ff[1]);
      kw_ping = t0len_ff == 3'd4 && upcase(t0_ff[0]) == "P" && upcase(t0_ff[1]) == "I"
                && upcase(t0_ff[2]) == "N" && upcase(t0_ff[3]) == "G";
      kw_set = t0len_ff == 3'd3 && u == "S" && upcase(t0_ff[1]) == "E"
               && upcase(t0_ff[2]) == "T";
      kw_get = t0len_ff == 3'd3 && u == "G" && upcase(t0_ff[1]) == "E"
               && upcase(t0_ff[2]) == "T";
      kw_wrp = t0len_ff == 3'd3 && u == "W" && upcase(t0_ff[1]) == "R"
               && upcase(t0_ff[2]) == "P";
      kw_rdp = t0len_ff == 3'd3 && u == "R" && upcase(t0_ff[1]) == "D"
               && upcase(t0_ff[2]) == "P";
      case (state_ff)
         FS_COLLECT: begin
            if (req_valid) begin
               if (!is_end) begin
                  if (len_ff != AW'(LineCapacity - 1)) begin
                     len_in = len_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  pins_in = {req_data.pins_port0, req_data.pins_port1,
                             req_data.pins_port2, req_data.pins_port3};
                  idx_in = '0;
                  ntok_in = '0;
                  tpos_in = '0;
                  intok_in = 1'b0;
                  many_in = 1'b0;
                  t0len_in = '0;
                  t1one_in = 1'b0;
                  t2len_in = '0;
                  t3one_in = 1'b0;
                  t1_in = 8'h00;
                  t3_in = 8'h00;
                  state_in = (len_ff == '0) ? FS_DECIDE : FS_READ;
               end
            end
         end
         FS_READ: begin
            // address registered, data arrives next cycle
            state_in = FS_SCAN;
         end
         FS_SCAN: begin
            if (blank) begin
               intok_in = 1'b0;
            end else if (!many_ff) begin
               if (!intok_ff) begin
                  if (ntok_ff == TW'(TokenLimit)) begin
                     many_in = 1'b1;
                  end else begin
                     ntok_in = ntok_ff + 1'b1;
                     intok_in = 1'b1;
                     tpos_in = 3'd1;
                     case (ntok_ff)
                        TW'(0): begin
                           t0_in[0] = rd_data;
                           t0len_in = 3'd1;
                        end
                        TW'(1): begin
                           t1_in = rd_data;
                           t1one_in = 1'b1;
                        end
                        TW'(2): begin
                           t2_in[0] = rd_data;
                           t2len_in = 2'd1;
                        end
                        TW'(3): begin
                           t3_in = rd_data;
                           t3one_in = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end else begin
                  if (tpos_ff != 3'd7) begin
                     tpos_in = tpos_ff + 1'b1;
                  end
                  case (ntok_ff)
                     TW'(1): begin
                        if (tpos_ff < 3'd4) begin
                           t0_in[tpos_ff[1:0]] = rd_data;
                        end
                        if (tpos_ff < 3'd5) begin
                           t0len_in = tpos_ff + 1'b1;
                        end
                     end
                     TW'(2): t1one_in = 1'b0;
                     TW'(3): begin
                        if (tpos_ff == 3'd1) begin
                           t2_in[1] = rd_data;
                        end
                        t2len_in = (tpos_ff == 3'd1) ? 2'd2 : 2'd3;
                     end
                     TW'(4): t3one_in = 1'b0;
                     default: ;
                  endcase
               end
            end
            if (idx_ff == len_ff - 1'b1) begin
               state_in = FS_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = FS_READ;
            end
         end
         FS_DECIDE: begin
            len_in = '0;
            ovf_in = 1'b0;
            job_in.cmd = CMD_ERR;
            job_in.port = p_d[1:0];
            job_in.bit_sel = b_d[2:0];
            job_in.value = v_d[0];
            job_in.data = {hn[3:0], ln[3:0]};
            job_in.pins = pins_ff;
            state_in = FS_PUSH;
            if (!ovf_ff && !many_ff) begin
               if (ntok_ff == '0) begin
                  state_in = FS_COLLECT;
               end else if (ntok_ff == TW'(1) && kw_ping) begin
                  job_in.cmd = CMD_PING;
               end else if (ntok_ff == TW'(4) && kw_set) begin
                  job_in.bit_sel = t2_ff[0][2:0];
                  if (t1one_ff && t1_ff >= "0" && t1_ff <= "3"
                      && t2len_ff == 2'd1 && t2_ff[0] >= "0" && t2_ff[0] <= "7"
                      && t3one_ff && t3_ff >= "0" && t3_ff <= "1"
                      && !(t1_ff == "3" && t2_ff[0] <= "1")) begin
                     job_in.cmd = CMD_SET;
                  end
               end else if (ntok_ff == TW'(3) && kw_get) begin
                  if (t1one_ff && t1_ff >= "0" && t1_ff <= "3"
                      && t2len_ff == 2'd1 && t2_ff[0] >= "0" && t2_ff[0] <= "7") begin
                     job_in.cmd = CMD_GET;
                  end
               end else if (ntok_ff == TW'(3) && kw_wrp) begin
                  if (t1one_ff && t1_ff >= "0" && t1_ff <= "2"
                      && t2len_ff == 2'd2 && !hn[4] && !ln[4]) begin
                     job_in.cmd = CMD_WRP;
                  end
               end else if (ntok_ff == TW'(2) && kw_rdp) begin
                  if (t1one_ff && t1_ff >= "0" && t1_ff <= "3") begin
                     job_in.cmd = CMD_RDP;
                  end
               end
            end
         end
         FS_PUSH: begin
            if (job_ready) begin
               state_in = FS_COLLECT;
            end
         end
         default: state_in = FS_COLLECT;
      endcase
   end

   // scan only reads stored entries
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> idx_ff < len_ff)
      else $error("scan index beyond line");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_PUSH && !job_ready) |=> state_ff == FS_PUSH && $stable(job_ff))
      else $error("job changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == FS_DECIDE |=> len_ff == '0 && !ovf_ff)
      else $error("line not cleared at end");

endmodule

// ===== hdl/sgci_back.sv =====
`timescale 1ns / 1ps
module sgci_back
   import sgci_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [7:0]     latch_ff [4];
   logic [7:0]     latch_in [4];
   logic [7:0]     text_ff [6];
   logic [7:0]     text_in [6];
   logic [2:0]     tlen_ff, tlen_in;
   logic [2:0]     pos_ff, pos_in;
   logic [7:0]     pin_byte;

   assign job_ready = state_ff == BS_IDLE;
   assign rsp_valid = state_ff == BS_SEND;
   assign pin_byte = job_ff.pins[8*(3 - {1'b0, job_ff.port}) +: 8];
   assign rsp_data.tx_byte = text_ff[pos_ff];
   assign rsp_data.reply_last = pos_ff == tlen_ff - 1'b1;
   assign rsp_data.latch_port0 = latch_ff[0];
   assign rsp_data.latch_port1 = latch_ff[1];
   assign rsp_data.latch_port2 = latch_ff[2];
   assign rsp_data.latch_port3 = latch_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_IDLE;
         latch_ff <= '{default: 8'hFF};
      end else begin
         state_ff <= state_in;
         latch_ff <= latch_in;
      end
      job_ff <= job_in;
      text_ff <= text_in;
      tlen_ff <= tlen_in;
      pos_ff <= pos_in;
   end

   // execute the command, then stream reply bytes
   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      latch_in = latch_ff;
      text_in = text_ff;
      tlen_in = tlen_ff;
      pos_in = pos_ff;
      case (state_ff)
         BS_IDLE: begin
            if (job_valid) begin
               job_in = job_data;
               state_in = BS_EXEC;
            end
         end
         BS_EXEC: begin
            pos_in = '0;
            text_in = '{default: CHAR_LF};
            case (job_ff.cmd)
               CMD_PING: begin
                  text_in[0] = "P"; text_in[1] = "O"; text_in[2] = "N";
                  text_in[3] = "G"; text_in[4] = CHAR_CR;
                  tlen_in = 3'd6;
               end
               CMD_SET: begin
                  latch_in[job_ff.port][job_ff.bit_sel] = job_ff.value;
                  text_in[0] = "O"; text_in[1] = "K"; text_in[2] = CHAR_CR;
                  tlen_in = 3'd4;
               end
               CMD_WRP: begin
                  latch_in[job_ff.port] = job_ff.data;
                  text_in[0] = "O"; text_in[1] = "K"; text_in[2] = CHAR_CR;
                  tlen_in = 3'd4;
               end
               CMD_GET: begin
                  text_in[0] = pin_byte[job_ff.bit_sel] ? "1" : "0";
                  text_in[1] = CHAR_CR;
                  tlen_in = 3'd3;
               end
               CMD_RDP: begin
                  text_in[0] = hex_char(pin_byte[7:4]);
                  text_in[1] = hex_char(pin_byte[3:0]);
                  text_in[2] = CHAR_CR;
                  tlen_in = 3'd4;
               end
               default: begin
                  text_in[0] = "E"; text_in[1] = "R"; text_in[2] = "R";
                  text_in[3] = CHAR_CR;
                  tlen_in = 3'd5;
               end
            endcase
            state_in = BS_SEND;
         end
         BS_SEND: begin
            if (rsp_ready) begin
               if (pos_ff == tlen_ff - 1'b1) begin
                  state_in = BS_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.reply_last) |-> rsp_data.tx_byte == CHAR_LF)
      else $error("last reply byte is not LF");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == BS_SEND |-> !$isunknown(tlen_ff) && pos_ff < tlen_ff)
      else $error("reply index out of range");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == BS_SEND |=> $stable(latch_ff[3][1:0]))
      else $error("uart pins of port 3 changed");

endmodule

// ===== hdl/serial_gpio_command_interpreter_top.sv =====
`timescale 1ns / 1ps
// Serial GPIO command interpreter.
// req channel: one received character per request, with the four pin
// samples alongside; the pins are used from the request that ends the line.
// rsp channel: one reply character per beat, reply_last on the closing LF,
// with the four latch values as they stand after the command.
// An ordinary character goes into the line buffer. A CR or LF starts the
// line scan: the line buffer (a RAM with registered read) is walked one
// entry at a time, in a read state then a scan state, and the line is
// classified; then the job passes a one-deep queue to the executor, which
// runs it in its execute state, then sends the reply bytes (up to 6). The front can
// collect the next line while the executor still sends a reply.
// Reset empties the line, clears the overflow flag and sets all four latches
// to 0xFF. A stalled receiver holds the reply byte; the executor then stops
// taking jobs and the front stops taking characters once its job is queued.
module serial_gpio_command_interpreter_top
   import sgci_pkg::*;
#(
   parameter int LINE_CAPACITY = 32,
   parameter int TOKEN_LIMIT   = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    job_valid;
   logic    job_ready;
   job_type job_data;

   sgci_front #(.LineCapacity(LINE_CAPACITY), .TokenLimit(TOKEN_LIMIT)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data)
   );

   sgci_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
